/* rtl/core/ffa_pkg.sv */
package ffa_pkg;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_RB0, S_RB1, S_RB2, S_RB3, S_PREP, S_RD, S_CHK, S_AL1,
    S_SHUP_RD, S_SHUP_WR, S_SPLIT, S_AL_FIN, S_AL_G, S_FR1, S_FR_N,
    S_FR_P0, S_FR_P, S_FR_M, S_FR_M2, S_SHDN_RD, S_SHDN_WR, S_DONE
  } state_t;

  // one table entry
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } ent_t;

  // shared adder operands
  localparam int ALU_W = 34;
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_NRDY = 2'd3;

  // request kinds
  localparam logic K_ALLOC = 1'b0;
  localparam logic K_FREE  = 1'b1;

  // register indexes
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic [32:0] MIN_BASE = 33'h1000;

endpackage

/* rtl/core/ffa_alu.sv */
module ffa_alu import ffa_pkg::*; (
  input  alu_req_t         req,
  output logic [ALU_W:0]   res
);

  // add or subtract, top bit is carry or borrow
  assign res = req.sub ? ({1'b0, req.a} - {1'b0, req.b})
                       : ({1'b0, req.a} + {1'b0, req.b});

endmodule

/* rtl/core/ffa_table.sv */
module ffa_table import ffa_pkg::*; #(
  parameter int DEPTH = 64,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  ent_t          wdata,
  input  logic [IW-1:0] raddr,
  output ent_t          rdata
);

  ent_t mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/first_fit_block_allocator.sv */
// channel  | direction | contents
// s_*      | in        | tdata: req_size, release_addr; tuser: kind
// m_*      | out       | tdata: grant_addr, status, used_bytes, block_total, arena_bytes
// cfg_*    | in        | write of arena_start (index 0) or arena_limit (index 1)
//
// an allocate reads, then checks, each table entry scanned, and moves entries up
// by a read and a write each to open a split slot; a free scans alike and moves
// entries down after a merge. all walks go through the table's one read port and
// one write port. a configuration write triggers a table rebuild; requests wait.
// reset leaves the arena invalid and the table empty.
// a finished result waits in the output register; the next request is taken
// meanwhile and holds only at its end if the result is still not taken.
module first_fit_block_allocator import ffa_pkg::*; #(
  parameter int MAX_BLOCKS  = 64,
  parameter int HDR_BYTES   = 20,
  parameter int ALIGN_BYTES = 8,
  localparam int IW    = $clog2(MAX_BLOCKS),
  localparam int CW    = $clog2(MAX_BLOCKS + 1),
  localparam int OUT_W = ((98 + CW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,   // req_size, release_addr
  input  logic             s_tuser,   // kind
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // grant_addr, status, used_bytes, block_total, arena_bytes
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [31:0]      cfg_data
);

  localparam logic [ALU_W-1:0] HDR_W = ALU_W'(HDR_BYTES);
  localparam logic [ALU_W-1:0] AM_W  = ALU_W'(ALIGN_BYTES - 1);
  localparam logic [ALU_W-1:0] HA_W  = ALU_W'(HDR_BYTES + ALIGN_BYTES);
  localparam logic [ALU_W-1:0] HAM_W = ALU_W'(HDR_BYTES + ALIGN_BYTES - 1);
  localparam logic [ALU_W:0]   RMASK = ~((ALU_W + 1)'(ALIGN_BYTES - 1));
  localparam logic [CW-1:0]    MAXC  = CW'(MAX_BLOCKS);

  state_t state, state_next;

  logic          pend;
  logic [31:0]   arena_start, arena_limit, arena_len;
  logic          arena_ok;
  logic [32:0]   base_r;
  logic [33:0]   tmp;
  logic [CW-1:0] cnt, idx, k;
  logic [1:0]    dsh;
  logic [31:0]   used, need, rest, grant_r;
  logic          kind_r;
  logic [31:0]   size_r, addr_r;
  logic [1:0]    status_r;
  ent_t          e, p;
  logic [31:0]   n_size;
  logic          n_free;

  alu_req_t      alu_req;
  logic [ALU_W:0] res;
  logic [ALU_W:0] rnd;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  ent_t          wdata, rdata;

  logic [CW-1:0] idx_inc, idx_dec, k_dec, k_inc;
  logic [CW:0]   kd;
  logic          out_free;

  ffa_alu u_alu (.req(alu_req), .res(res));

  ffa_table #(.DEPTH(MAX_BLOCKS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rnd      = res & RMASK;
  assign idx_inc  = idx + 1'b1;
  assign idx_dec  = idx - 1'b1;
  assign k_dec    = k - 1'b1;
  assign k_inc    = k + 1'b1;
  assign kd       = {1'b0, k} + (CW + 1)'(dsh);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && !pend;

  // sequencer: next state, adder operands, table port
  always_comb begin
    state_next = state;
    alu_req    = '0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = '0;
    case (state)
      S_IDLE: begin
        if (pend) state_next = S_RB0;
        else if (s_tvalid) state_next = S_PREP;
      end
      S_RB0: begin
        alu_req    = '{a: ALU_W'(arena_start), b: AM_W, sub: 1'b0};
        state_next = S_RB1;
      end
      S_RB1: begin
        alu_req    = '{a: ALU_W'(base_r), b: HA_W, sub: 1'b0};
        state_next = S_RB2;
      end
      S_RB2: begin
        alu_req    = '{a: tmp, b: ALU_W'(arena_limit), sub: 1'b1};
        state_next = S_RB3;
      end
      S_RB3: begin
        alu_req    = '{a: ALU_W'(arena_limit), b: ALU_W'(base_r), sub: 1'b1};
        we         = arena_ok;
        wdata      = '{start: base_r[31:0], size: res[31:0], free: 1'b1};
        state_next = S_IDLE;
      end
      S_PREP: begin
        alu_req = '{a: ALU_W'(size_r), b: HAM_W, sub: 1'b0};
        if (kind_r == K_ALLOC) begin
          if (!arena_ok || size_r == '0 || rnd[ALU_W:32] != '0) state_next = S_DONE;
          else state_next = S_RD;
        end else begin
          if (addr_r == '0 || !arena_ok) state_next = S_DONE;
          else state_next = S_RD;
        end
      end
      S_RD: begin
        raddr      = idx[IW-1:0];
        state_next = (idx >= cnt) ? S_DONE : S_CHK;
      end
      S_CHK: begin
        if (kind_r == K_ALLOC) begin
          alu_req    = '{a: ALU_W'(rdata.size), b: ALU_W'(need), sub: 1'b1};
          state_next = (rdata.free && !res[ALU_W]) ? S_AL1 : S_RD;
        end else begin
          alu_req    = '{a: ALU_W'(rdata.start), b: HDR_W, sub: 1'b0};
          state_next = (res[33:0] == {2'b00, addr_r} && !rdata.free) ? S_FR1 : S_RD;
        end
      end
      S_AL1: begin
        alu_req    = '{a: ALU_W'(rest), b: HA_W, sub: 1'b1};
        state_next = (!res[ALU_W] && cnt < MAXC) ? S_SHUP_RD : S_AL_FIN;
      end
      S_SHUP_RD: begin
        raddr      = k_dec[IW-1:0];
        state_next = (k > idx_inc) ? S_SHUP_WR : S_SPLIT;
      end
      S_SHUP_WR: begin
        we         = 1'b1;
        waddr      = k[IW-1:0];
        wdata      = rdata;
        state_next = S_SHUP_RD;
      end
      S_SPLIT: begin
        alu_req    = '{a: ALU_W'(e.start), b: ALU_W'(need), sub: 1'b0};
        we         = 1'b1;
        waddr      = idx_inc[IW-1:0];
        wdata      = '{start: res[31:0], size: rest, free: 1'b1};
        state_next = S_AL_FIN;
      end
      S_AL_FIN: begin
        alu_req    = '{a: ALU_W'(used), b: ALU_W'(e.size), sub: 1'b0};
        we         = 1'b1;
        waddr      = idx[IW-1:0];
        wdata      = '{start: e.start, size: e.size, free: 1'b0};
        state_next = S_AL_G;
      end
      S_AL_G: begin
        alu_req    = '{a: ALU_W'(e.start), b: HDR_W, sub: 1'b0};
        state_next = S_DONE;
      end
      S_FR1: begin
        alu_req    = '{a: ALU_W'(used), b: ALU_W'(e.size), sub: 1'b1};
        raddr      = idx_inc[IW-1:0];
        state_next = (idx_inc < cnt) ? S_FR_N : S_FR_P0;
      end
      S_FR_N: state_next = S_FR_P0;
      S_FR_P0: begin
        raddr      = idx_dec[IW-1:0];
        state_next = (idx != '0) ? S_FR_P : S_FR_M;
      end
      S_FR_P: state_next = S_FR_M;
      S_FR_M: begin
        alu_req    = '{a: ALU_W'(e.size), b: ALU_W'(n_size), sub: 1'b0};
        state_next = S_FR_M2;
      end
      S_FR_M2: begin
        alu_req = '{a: ALU_W'(p.size), b: ALU_W'(e.size), sub: 1'b0};
        we      = 1'b1;
        if (p.free) begin
          waddr      = idx_dec[IW-1:0];
          wdata      = '{start: p.start, size: res[31:0], free: 1'b1};
          state_next = S_SHDN_RD;
        end else begin
          waddr      = idx[IW-1:0];
          wdata      = '{start: e.start, size: e.size, free: 1'b1};
          state_next = n_free ? S_SHDN_RD : S_DONE;
        end
      end
      S_SHDN_RD: begin
        raddr      = kd[IW-1:0];
        state_next = (kd < {1'b0, cnt}) ? S_SHDN_WR : S_DONE;
      end
      S_SHDN_WR: begin
        we         = 1'b1;
        waddr      = k[IW-1:0];
        wdata      = rdata;
        state_next = S_SHDN_RD;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // configuration registers and rebuild request, a write during a rebuild
  // queues another one
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_start <= '0;
      arena_limit <= '0;
      pend        <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_START) arena_start <= cfg_data;
      else arena_limit <= cfg_data;
      pend <= 1'b1;
    end else if (state == S_IDLE && pend) begin
      pend <= 1'b0;
    end
  end

  // control state of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_ok <= 1'b0;
      cnt      <= '0;
      used     <= '0;
    end else begin
      case (state)
        S_RB2: arena_ok <= res[ALU_W] && (base_r >= MIN_BASE);
        S_RB3: begin
          cnt  <= arena_ok ? CW'(1) : '0;
          used <= '0;
        end
        S_SPLIT:  cnt  <= cnt + 1'b1;
        S_AL_FIN: used <= res[31:0];
        S_FR1:    used <= res[31:0];
        S_SHDN_RD: begin
          if (!(kd < {1'b0, cnt})) cnt <= cnt - CW'(dsh);
        end
        default: ;
      endcase
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kind_r <= s_tuser;
        size_r <= s_tdata[31:0];
        addr_r <= s_tdata[63:32];
      end
      S_RB0: base_r <= rnd[32:0];
      S_RB1: tmp <= res[33:0];
      S_RB3: arena_len <= res[31:0];
      S_PREP: begin
        grant_r  <= '0;
        idx      <= '0;
        need     <= rnd[31:0];
        status_r <= ST_OK;
        if (kind_r == K_ALLOC) begin
          if (!arena_ok || size_r == '0) status_r <= ST_NRDY;
          else if (rnd[ALU_W:32] != '0) status_r <= ST_OOM;
        end else if (addr_r != '0 && !arena_ok) begin
          status_r <= ST_NRDY;
        end
      end
      S_RD: begin
        if (idx >= cnt) status_r <= (kind_r == K_ALLOC) ? ST_OOM : ST_BAD;
      end
      S_CHK: begin
        e    <= rdata;
        rest <= res[31:0];
        if (state_next == S_RD) idx <= idx_inc;
      end
      S_AL1: k <= cnt;
      S_SHUP_WR: k <= k_dec;
      S_SPLIT: e.size <= need;
      S_AL_G: grant_r <= res[31:0];
      S_FR1: begin
        n_free <= 1'b0;
        n_size <= '0;
        p.free <= 1'b0;
      end
      S_FR_N: begin
        n_size <= rdata.size;
        n_free <= rdata.free;
      end
      S_FR_P: p <= rdata;
      S_FR_M: begin
        if (n_free) e.size <= res[31:0];
      end
      S_FR_M2: begin
        if (p.free) begin
          k   <= idx;
          dsh <= n_free ? 2'd2 : 2'd1;
        end else begin
          k   <= idx_inc;
          dsh <= 2'd1;
        end
      end
      S_SHDN_WR: k <= k_inc;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= OUT_W'({(arena_ok ? arena_len : 32'd0), cnt, used, status_r, grant_r});
    end
  end

  // table never grows past its depth
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt <= MAXC)
    else $error("block count beyond table depth");

  // invalid arena keeps an empty table and no used bytes, except in the
  // last rebuild step where the count is still being cleared
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (!arena_ok && state != S_RB3) |-> (cnt == '0 && used == '0))
    else $error("state left behind with invalid arena");

  // one request at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while busy");

endmodule

/* tb/sv/ffa_checker.sv */
`timescale 1ns / 1ps

module ffa_checker import ffa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [63:0]  s_tdata,   // req_size, release_addr
  input  logic         s_tuser,   // kind
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,   // grant_addr, status, used_bytes, block_total, arena_bytes
  input  logic         cfg_we,
  input  logic         cfg_idx,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  localparam int TABLE_DEPTH = 64;
  localparam int HDR = 20;
  localparam longint unsigned SPLIT_MIN = 28;

  // first member is the most significant, so grant lands in the low bits
  typedef struct packed {
    logic [31:0] arena;
    logic [6:0]  total;
    logic [31:0] used;
    logic [1:0]  status;
    logic [31:0] grant;
  } alloc_result_t;

  // allocator shadow state
  bit [31:0] arena_start_q, arena_limit_q, arena_base_q;
  bit [31:0] ent_start[TABLE_DEPTH];
  bit [31:0] ent_size[TABLE_DEPTH];
  bit        ent_free[TABLE_DEPTH];
  int        ent_count;
  bit [31:0] used_total;
  bit        arena_valid;

  alloc_result_t result_q[$];

  function automatic void rebuild_table();
    longint unsigned b;
    b = ({32'b0, arena_start_q} + 7) & 64'hFFFF_FFFF_FFFF_FFF8;
    used_total = 0;
    arena_valid = !((b + 28 >= {32'b0, arena_limit_q}) || (b < 64'h1000));
    if (arena_valid) begin
      arena_base_q = b[31:0];
      ent_start[0] = arena_base_q;
      ent_size[0] = arena_limit_q - arena_base_q;
      ent_free[0] = 1'b1;
      ent_count = 1;
    end else begin
      arena_base_q = 0;
      ent_count = 0;
    end
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < ent_count; k++) begin
      ent_start[k] = ent_start[k+1];
      ent_size[k] = ent_size[k+1];
      ent_free[k] = ent_free[k+1];
    end
    if (ent_count > 0) ent_count--;
  endfunction

  function automatic bit [31:0] first_fit(bit [31:0] sz, output logic [1:0] st);
    longint unsigned need, rest;
    if (!arena_valid || sz == 0) begin
      st = ST_NRDY;
      return 0;
    end
    need = ({32'b0, sz} + HDR + 7) & 64'hFFFF_FFFF_FFFF_FFF8;
    if (need > 64'hFFFF_FFFF) begin
      st = ST_OOM;
      return 0;
    end
    for (int i = 0; i < ent_count; i++) begin
      if (!ent_free[i] || {32'b0, ent_size[i]} < need) continue;
      rest = {32'b0, ent_size[i]} - need;
      // split off the tail when it can hold a block and the table has room
      if (rest >= SPLIT_MIN && ent_count < TABLE_DEPTH) begin
        for (int k = ent_count; k > i + 1; k--) begin
          ent_start[k] = ent_start[k-1];
          ent_size[k] = ent_size[k-1];
          ent_free[k] = ent_free[k-1];
        end
        ent_start[i+1] = ent_start[i] + need[31:0];
        ent_size[i+1] = rest[31:0];
        ent_free[i+1] = 1'b1;
        ent_size[i] = need[31:0];
        ent_count++;
      end
      ent_free[i] = 1'b0;
      used_total += ent_size[i];
      st = ST_OK;
      return ent_start[i] + HDR;
    end
    st = ST_OOM;
    return 0;
  endfunction

  function automatic logic [1:0] release_block(bit [31:0] addr);
    int i;
    if (addr == 0) return ST_OK;
    if (!arena_valid) return ST_NRDY;
    for (i = 0; i < ent_count; i++)
      if ({32'b0, ent_start[i]} + HDR == {32'b0, addr} && !ent_free[i]) break;
    if (i >= ent_count) return ST_BAD;
    ent_free[i] = 1'b1;
    used_total -= ent_size[i];
    // merge with free successor, then with free predecessor
    if (i + 1 < ent_count && ent_free[i+1]) begin
      ent_size[i] += ent_size[i+1];
      drop_entry(i + 1);
    end
    if (i > 0 && ent_free[i-1]) begin
      ent_size[i-1] += ent_size[i];
      drop_entry(i);
    end
    return ST_OK;
  endfunction

  function automatic alloc_result_t serve_request(logic k, bit [31:0] sz, bit [31:0] ad);
    alloc_result_t r;
    r.grant = 0;
    if (k == K_ALLOC) r.grant = first_fit(sz, r.status);
    else r.status = release_block(ad);
    r.used = used_total;
    r.total = ent_count[6:0];
    r.arena = arena_valid ? arena_limit_q - arena_base_q : 32'd0;
    return r;
  endfunction

  // track config, predict on request, compare on result
  always @(posedge clk) begin
    alloc_result_t exp_r, act_r;
    if (rst) begin
      arena_start_q = 0;
      arena_limit_q = 0;
      rebuild_table();
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_START) arena_start_q = cfg_data;
        else arena_limit_q = cfg_data;
        rebuild_table();
      end
      if (s_tvalid && s_tready)
        result_q.push_back(serve_request(s_tuser, s_tdata[31:0], s_tdata[63:32]));
      if (m_tvalid && m_tready) begin
        act_r = m_tdata[104:0];
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, act_r);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r.grant !== act_r.grant)
            $display("%0t: grant_addr expected %h actual %h", $time, exp_r.grant, act_r.grant);
          if (exp_r.status !== act_r.status)
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, act_r.status);
          if (exp_r.used !== act_r.used)
            $display("%0t: used_bytes expected %h actual %h", $time, exp_r.used, act_r.used);
          if (exp_r.total !== act_r.total)
            $display("%0t: block_total expected %0d actual %0d", $time, exp_r.total,
                     act_r.total);
          if (exp_r.arena !== act_r.arena)
            $display("%0t: arena_bytes expected %h actual %h", $time, exp_r.arena, act_r.arena);
          if (exp_r !== act_r) fail_count <= fail_count + 1;
        end
      end
    end
    pending <= result_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import ffa_pkg::*;

  localparam int OUT_W = 112;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int N_PHASES = 8;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [63:0]      s_tdata;   // req_size, release_addr
  logic             s_tuser;   // kind
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;   // grant_addr, status, used_bytes, block_total, arena_bytes
  logic             cfg_we;
  logic             cfg_idx;
  logic [31:0]      cfg_data;

  int fail_count, pending;
  int n_sent, n_got, n_alloc, n_free, cycles;
  bit hold_done;
  bit [31:0] live_addr[$];

  bit [31:0] phase_start[N_PHASES] = '{32'h1000, 32'h0FFF, 32'hFFFFF001, 32'h1000,
                                        32'hFFFFFFF0, 32'h0, 32'h1234, 32'h2000};
  bit [31:0] phase_limit[N_PHASES] = '{32'h2000, 32'h1800, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                        32'hFFFFFFFF, 32'h0, 32'h148C, 32'h201D};
  int        phase_items[N_PHASES] = '{150, 120, 130, 130, 25, 25, 120, 25};

  first_fit_block_allocator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  ffa_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // count results and remember granted addresses
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_got++;
      if (m_tdata[33:32] == ST_OK && m_tdata[31:0] != 0) live_addr.push_back(m_tdata[31:0]);
    end
  end

  // receiver: random stalls, one long hold-off, one quiet window
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && n_sent >= 200) begin
        hold_done = 1;
        m_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end else if (n_sent >= 300 && n_sent <= 420) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 17);
      end
    end
  end

  task automatic push_request(logic k, bit [31:0] sz, bit [31:0] ad);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= {ad, sz};
    forever begin
      @(negedge clk);
      if (s_tready) break;
      @(posedge clk);
    end
    @(posedge clk);
    n_sent++;
    if (k == K_ALLOC) n_alloc++;
    else n_free++;
    // sender gaps, none in the quiet stretch
    if ((n_sent < 300 || n_sent > 420) && $urandom_range(0, 99) < 17) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (n_got != n_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, bit [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_arena(bit [31:0] st, bit [31:0] lim);
    wait_drained();
    write_reg(CFG_START, st);
    write_reg(CFG_LIMIT, lim);
    live_addr.delete();
  endtask

  task automatic random_request();
    int pick, idx;
    bit [31:0] sz, ad;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      push_request(K_ALLOC, $urandom_range(1, 120), $urandom);
    end else if (pick < 62) begin
      push_request(K_ALLOC, $urandom_range(0, 700), $urandom);
    end else if (pick < 68) begin
      sz = $urandom;
      push_request(K_ALLOC, sz, $urandom);
    end else if (pick < 93 && live_addr.size() > 0) begin
      idx = $urandom_range(0, live_addr.size() - 1);
      ad = live_addr[idx];
      live_addr.delete(idx);
      push_request(K_FREE, $urandom, ad);
    end else begin
      // broken frees: random, null, or just off a granted address
      case ($urandom_range(0, 2))
        0: ad = $urandom;
        1: ad = 0;
        default: ad = (live_addr.size() > 0) ? live_addr[0] + 8 : 32'h1014;
      endcase
      push_request(K_FREE, $urandom, ad);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = K_ALLOC;
    cfg_we = 1'b0;
    cfg_idx = CFG_START;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // arena not ready after reset
    push_request(K_ALLOC, 32'd5, 32'd0);
    push_request(K_FREE, 32'd0, 32'd0);
    push_request(K_FREE, 32'd0, 32'h1234);

    // directed corner cases on a small arena
    set_arena(32'h1000, 32'h2000);
    push_request(K_ALLOC, 32'd0, 32'd0);
    push_request(K_ALLOC, 32'hFFFFFFFF, 32'd0);
    push_request(K_ALLOC, 32'hFFFFFFEC, 32'd0);
    push_request(K_ALLOC, 32'hFFFFFFE0, 32'd0);
    push_request(K_ALLOC, 32'd4096, 32'd0);
    push_request(K_ALLOC, 32'd1, 32'd0);
    push_request(K_ALLOC, 32'd100, 32'd0);
    push_request(K_ALLOC, 32'd40, 32'd0);
    push_request(K_FREE, 32'd0, 32'h1014);
    push_request(K_FREE, 32'd0, 32'h1014);
    push_request(K_FREE, 32'd0, 32'h1015);
    push_request(K_FREE, 32'hFFFFFFFF, 32'hFFFFFFFF);
    push_request(K_FREE, 32'd0, 32'h1034);
    push_request(K_ALLOC, 32'd4060, 32'd0);
    push_request(K_FREE, 32'd0, 32'h1014);
    // fill the table with tiny blocks
    repeat (66) push_request(K_ALLOC, 32'd1, 32'd0);
    wait_drained();

    // random phases over several arena settings
    for (int p = 0; p < N_PHASES; p++) begin
      set_arena(phase_start[p], phase_limit[p]);
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == 3 && n == 60) wait_drained();
        random_request();
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d requests: %0d allocates, %0d frees", n_sent, n_alloc, n_free);
    $display("arena settings: %0d, including invalid, wrapping and tiny arenas", N_PHASES + 1);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
